// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SADR_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sadr check failed");
`define SADR_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sadr sequence check failed");
`else
`define SADR_CHECK(lbl, cond)
`define SADR_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/sadr_pkg.sv -----
// Types and codes for the slot allocator with deferred reclaim.
// No dependencies.
package sadr_pkg;

  localparam logic [1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [1:0] ACT_BEGIN   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_COMMIT  = 2'd3;

  localparam logic [1:0] KIND_ANSWER    = 2'd0;
  localparam logic [1:0] KIND_WR_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_WR_ERROR  = 2'd2;
  localparam logic [1:0] KIND_DONE      = 2'd3;

  localparam logic [2:0] STAT_HIT        = 3'd0;
  localparam logic [2:0] STAT_ALLOC      = 3'd1;
  localparam logic [2:0] STAT_NULL       = 3'd2;
  localparam logic [2:0] STAT_FULL_FIRST = 3'd3;
  localparam logic [2:0] STAT_FULL       = 3'd4;
  localparam logic [2:0] STAT_COMMITTED  = 3'd5;
  localparam logic [2:0] STAT_NONE       = 3'd0;

  localparam int         CFG_IDX_W   = 2;
  localparam logic [1:0] CFG_FRAMES  = 2'd0;
  localparam logic [1:0] CFG_SLOTS   = 2'd1;
  localparam logic [2:0] RST_FRAMES  = 3'd2;
  localparam logic [6:0] RST_SLOTS   = 7'd64;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] texture_id;
    logic [7:0]  sampler_id;
    logic [7:0]  generation;
    logic        refs_present;
    logic [1:0]  frame_number;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] slot;
    logic [2:0] status;
    logic       last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CK,
    ST_ALLOC,
    ST_ALLOC_RD,
    ST_BF_START,
    ST_BF_RD,
    ST_BF_EM,
    ST_SWEEP,
    ST_RL_RD,
    ST_RL_CK,
    ST_FINAL
  } state_t;

endpackage

// ----- rtl/core/sadr_front.sv -----
// Front end: accepts items into a two-entry queue for the back end.
// Depends on sadr_pkg.
module sadr_front import sadr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  cmd_t in_cmd,
  output logic q_valid,
  output cmd_t q_item,
  input  logic q_pop
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
  end

endmodule

// ----- rtl/core/sadr_back.sv -----
// Back end: entry table walks, free stack, retired lists, result sequencing.
// Depends on sadr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sadr_back import sadr_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int MAX_FRAMES = 4,
  localparam int SLW = $clog2(CAPACITY),
  localparam int CW  = $clog2(CAPACITY + 1),
  localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int FNW = $clog2(MAX_FRAMES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           init_i,
  input  logic [CW-1:0]  eff_slots,
  input  logic [FNW-1:0] eff_frames,
  input  logic           q_valid,
  input  cmd_t           q_item,
  output logic           q_pop,
  output logic           em_valid,
  output res_t           em,
  input  logic           em_ok
);

  localparam logic [SLW-1:0] LAST_IDX = SLW'(CAPACITY - 1);

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  res_t   pend_r, pend_nxt;
  logic [SLW-1:0] idx_r, idx_nxt;
  logic [CW-1:0]  bi_r, bi_nxt, bn_r, bn_nxt;
  logic [CW-1:0]  fc_r, fc_nxt;
  logic [FW-1:0]  cur_r, cur_nxt;
  logic           dirty_r, dirty_nxt, full_r, full_nxt;
  logic [CAPACITY-1:0] valid_r, exp_r, fs_wr_r;
  logic [CW-1:0]  rc_r [MAX_FRAMES];

  logic [31:0]    key_mem [CAPACITY];
  logic [SLW-1:0] fs_mem [CAPACITY];
  logic [SLW-1:0] rl_mem [MAX_FRAMES][CAPACITY];
  logic [31:0]    key_q;
  logic [SLW-1:0] fs_q, rl_q;
  logic           fs_wq;

  logic vclr, vset, xset, key_re, fs_re, fs_we, rl_re, rl_we, rc_inc, rc_clr;
  logic [SLW-1:0] fs_ra, alloc_slot, fs_unw;
  logic [FW-1:0]  fmod;
  logic [3:0]     rtmp;
  logic           can_retire;

  always_comb begin
    rtmp = 4'(cmd_r.frame_number);
    for (int k = 0; k < 3; k++) begin
      if (rtmp >= 4'(eff_frames)) rtmp = rtmp - 4'(eff_frames);
    end
    fmod = FW'(rtmp);
  end

  assign fs_unw     = SLW'(eff_slots - CW'(1) - fc_r);
  assign alloc_slot = fs_wq ? fs_q : fs_unw;
  assign can_retire = (rc_r[cur_r] < CW'(CAPACITY));

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    pend_nxt  = pend_r;
    idx_nxt   = idx_r;
    bi_nxt    = bi_r;
    bn_nxt    = bn_r;
    fc_nxt    = fc_r;
    cur_nxt   = cur_r;
    dirty_nxt = dirty_r;
    full_nxt  = full_r;
    q_pop = 1'b0; vclr = 1'b0; vset = 1'b0; xset = 1'b0;
    key_re = 1'b0; fs_re = 1'b0; fs_we = 1'b0; fs_ra = '0;
    rl_re = 1'b0; rl_we = 1'b0; rc_inc = 1'b0; rc_clr = 1'b0;
    em_valid = 1'b0;
    em = '0;
    case (state_r)
      ST_IDLE: begin
        if (!init_i && q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_item;
          idx_nxt = '0;
          case (q_item.action)
            ACT_LOOKUP: begin
              if (!q_item.refs_present) begin
                pend_nxt  = '{KIND_ANSWER, 6'd0, STAT_NULL, 1'b1};
                state_nxt = ST_FINAL;
              end else begin
                state_nxt = ST_LK_RD;
              end
            end
            ACT_BEGIN:   state_nxt = ST_BF_START;
            ACT_RELEASE: state_nxt = ST_RL_RD;
            default: begin
              pend_nxt  = '{KIND_DONE, 6'd0, dirty_r ? STAT_COMMITTED : STAT_NONE, 1'b1};
              dirty_nxt = 1'b0;
              state_nxt = ST_FINAL;
            end
          endcase
        end
      end
      ST_LK_RD: begin
        if (valid_r[idx_r]) begin
          key_re    = 1'b1;
          state_nxt = ST_LK_CK;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_ALLOC;
        end else begin
          idx_nxt = idx_r + SLW'(1);
        end
      end
      ST_LK_CK: begin
        if (key_q[31:8] == {cmd_r.texture_id, cmd_r.sampler_id}) begin
          if (key_q[7:0] == cmd_r.generation) begin
            pend_nxt  = '{KIND_ANSWER, 6'(idx_r), STAT_HIT, 1'b1};
            state_nxt = ST_FINAL;
          end else begin
            rl_we     = can_retire;
            rc_inc    = can_retire;
            vclr      = 1'b1;
            state_nxt = ST_ALLOC;
          end
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_ALLOC;
        end else begin
          idx_nxt   = idx_r + SLW'(1);
          state_nxt = ST_LK_RD;
        end
      end
      ST_ALLOC: begin
        if (fc_r == '0) begin
          pend_nxt  = '{KIND_ANSWER, 6'd0, full_r ? STAT_FULL : STAT_FULL_FIRST, 1'b1};
          full_nxt  = 1'b1;
          state_nxt = ST_FINAL;
        end else begin
          fs_re     = 1'b1;
          fs_ra     = SLW'(fc_r - CW'(1));
          fc_nxt    = fc_r - CW'(1);
          state_nxt = ST_ALLOC_RD;
        end
      end
      ST_ALLOC_RD: begin
        em_valid = 1'b1;
        em       = '{KIND_WR_ENTRY, 6'(alloc_slot), STAT_NONE, 1'b0};
        if (em_ok) begin
          vset      = 1'b1;
          dirty_nxt = 1'b1;
          pend_nxt  = '{KIND_ANSWER, 6'(alloc_slot), STAT_ALLOC, 1'b1};
          state_nxt = ST_FINAL;
        end
      end
      ST_BF_START: begin
        cur_nxt   = fmod;
        bn_nxt    = (rc_r[fmod] > CW'(CAPACITY - 1)) ? CW'(CAPACITY - 1) : rc_r[fmod];
        bi_nxt    = '0;
        state_nxt = ST_BF_RD;
      end
      ST_BF_RD: begin
        if (bi_r == bn_r) begin
          rc_clr    = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_SWEEP;
        end else begin
          rl_re     = 1'b1;
          state_nxt = ST_BF_EM;
        end
      end
      ST_BF_EM: begin
        em_valid = 1'b1;
        em       = '{KIND_WR_ERROR, 6'(rl_q), STAT_NONE, 1'b0};
        if (em_ok) begin
          dirty_nxt = 1'b1;
          if (fc_r < CW'(CAPACITY)) begin
            fs_we  = 1'b1;
            fc_nxt = fc_r + CW'(1);
          end
          bi_nxt    = bi_r + CW'(1);
          state_nxt = ST_BF_RD;
        end
      end
      ST_SWEEP: begin
        if (valid_r[idx_r] && exp_r[idx_r]) begin
          rl_we  = can_retire;
          rc_inc = can_retire;
          vclr   = 1'b1;
        end
        if (idx_r == LAST_IDX) begin
          pend_nxt  = '{KIND_DONE, 6'd0, STAT_NONE, 1'b1};
          state_nxt = ST_FINAL;
        end else begin
          idx_nxt = idx_r + SLW'(1);
        end
      end
      ST_RL_RD: begin
        if (valid_r[idx_r]) begin
          key_re    = 1'b1;
          state_nxt = ST_RL_CK;
        end else if (idx_r == LAST_IDX) begin
          pend_nxt  = '{KIND_DONE, 6'd0, STAT_NONE, 1'b1};
          state_nxt = ST_FINAL;
        end else begin
          idx_nxt = idx_r + SLW'(1);
        end
      end
      ST_RL_CK: begin
        xset = (key_q[31:16] == cmd_r.texture_id) && (key_q[7:0] == cmd_r.generation);
        if (idx_r == LAST_IDX) begin
          pend_nxt  = '{KIND_DONE, 6'd0, STAT_NONE, 1'b1};
          state_nxt = ST_FINAL;
        end else begin
          idx_nxt   = idx_r + SLW'(1);
          state_nxt = ST_RL_RD;
        end
      end
      ST_FINAL: begin
        em_valid = 1'b1;
        em       = pend_r;
        if (em_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    idx_r  <= idx_nxt;
    bi_r   <= bi_nxt;
    bn_r   <= bn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r    <= CW'(CAPACITY - 1);
      cur_r   <= '0;
      dirty_r <= 1'b1;
      full_r  <= 1'b0;
      valid_r <= '0;
      exp_r   <= '0;
      fs_wr_r <= '0;
      for (int f = 0; f < MAX_FRAMES; f++) rc_r[f] <= '0;
    end else if (init_i) begin
      fc_r    <= eff_slots - CW'(1);
      cur_r   <= '0;
      dirty_r <= 1'b1;
      full_r  <= 1'b0;
      valid_r <= '0;
      exp_r   <= '0;
      fs_wr_r <= '0;
      for (int f = 0; f < MAX_FRAMES; f++) rc_r[f] <= '0;
    end else begin
      fc_r    <= fc_nxt;
      cur_r   <= cur_nxt;
      dirty_r <= dirty_nxt;
      full_r  <= full_nxt;
      if (vclr) begin
        valid_r[idx_r] <= 1'b0;
        exp_r[idx_r]   <= 1'b0;
      end
      if (vset) begin
        valid_r[alloc_slot] <= 1'b1;
        exp_r[alloc_slot]   <= 1'b0;
      end
      if (xset) exp_r[idx_r] <= 1'b1;
      if (fs_we) fs_wr_r[fc_r[SLW-1:0]] <= 1'b1;
      if (rc_clr) rc_r[cur_r] <= '0;
      else if (rc_inc) rc_r[cur_r] <= rc_r[cur_r] + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (vset) key_mem[alloc_slot] <= {cmd_r.texture_id, cmd_r.sampler_id, cmd_r.generation};
    if (key_re) key_q <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fc_r[SLW-1:0]] <= rl_q;
    if (fs_re) begin
      fs_q  <= fs_mem[fs_ra];
      fs_wq <= fs_wr_r[fs_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rl_we) rl_mem[cur_r][rc_r[cur_r][SLW-1:0]] <= idx_r;
    if (rl_re) rl_q <= rl_mem[cur_r][bi_r[SLW-1:0]];
  end

  `SADR_CHECK(pop_only_idle, !q_pop || (state_r == ST_IDLE && !init_i))
  `SADR_CHECK(entry_not_slot0, !(em_valid && em.kind == KIND_WR_ENTRY) || em.slot != 6'd0)
  `SADR_CHECK_NEXT(last_ends_item, em_valid && em_ok && em.last, state_r == ST_IDLE)
  `SADR_CHECK(fc_bounded, fc_r <= CW'(CAPACITY))

endmodule

// ----- rtl/core/slot_allocator_deferred_reclaim_top.sv -----
// Top level of the slot allocator with deferred reclaim: config registers,
// output register. Depends on sadr_pkg, sadr_front, sadr_back.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | action..frame_number
//   out_    | output    | out_valid/out_stall| result_kind, slot, status, last
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Lookup walks the table one entry at a time, with an extra key-read step per valid
// entry; release walks every entry the same way. Begin frame emits each recycled
// slot, then sweeps all CAPACITY entries. Commit and null lookups skip the walks.
// The key-read step comes from the registered read port of the entry table.
// Reset and config writes clear the heap state registers in parallel; no clearing pass.
// Output stall holds the back end; the input queue takes two items meanwhile.
module slot_allocator_deferred_reclaim_top import sadr_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int MAX_FRAMES = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [15:0]          in_texture_id,
  input  logic [7:0]           in_sampler_id,
  input  logic [7:0]           in_generation,
  input  logic                 in_refs_present,
  input  logic [1:0]           in_frame_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_result_kind,
  output logic [5:0]           out_slot,
  output logic [2:0]           out_status,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]           cfg_data
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int FNW = $clog2(MAX_FRAMES + 1);

  logic [2:0]     frames_r;
  logic [6:0]     slots_r;
  logic           init_r;
  logic [CW-1:0]  eff_slots;
  logic [FNW-1:0] eff_frames;
  cmd_t           in_cmd, q_item;
  logic           q_valid, q_pop, em_valid, em_ok;
  res_t           em, res_r;
  logic           out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_cmd = '{in_action, in_texture_id, in_sampler_id, in_generation,
                    in_refs_present, in_frame_number};

  always_comb begin
    if (slots_r < 7'd2)                 eff_slots = CW'(2);
    else if (slots_r > 7'(CAPACITY))    eff_slots = CW'(CAPACITY);
    else                                eff_slots = CW'(slots_r);
    if (frames_r == 3'd0)                       eff_frames = FNW'(1);
    else if ({1'b0, frames_r} > 4'(MAX_FRAMES)) eff_frames = FNW'(MAX_FRAMES);
    else                                        eff_frames = FNW'(frames_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= RST_FRAMES;
      slots_r  <= RST_SLOTS;
      init_r   <= 1'b0;
    end else begin
      init_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAMES: begin
            frames_r <= cfg_data[2:0];
            init_r   <= 1'b1;
          end
          CFG_SLOTS: begin
            slots_r <= cfg_data;
            init_r  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  sadr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sadr_back #(
    .CAPACITY   (CAPACITY),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_i     (init_r),
    .eff_slots  (eff_slots),
    .eff_frames (eff_frames),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .em_valid   (em_valid),
    .em         (em),
    .em_ok      (em_ok)
  );

  assign em_ok = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (em_ok) out_valid_r <= em_valid;
  end

  always_ff @(posedge clk) begin
    if (em_ok && em_valid) res_r <= em;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_r.kind;
  assign out_slot        = res_r.slot;
  assign out_status      = res_r.status;
  assign out_last        = res_r.last;

endmodule

// ----- verif/tb_slot_allocator_deferred_reclaim_top.sv -----
// Testbench for slot_allocator_deferred_reclaim_top: random and directed lookups,
// frame starts, releases and commits checked against an in-bench heap predictor.
// Depends on sadr_pkg and the allocator RTL.
module tb_slot_allocator_deferred_reclaim_top import sadr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;
  localparam int MAXF = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [15:0] in_texture_id = '0;
  logic [7:0] in_sampler_id = '0;
  logic [7:0] in_generation = '0;
  logic in_refs_present = 1'b0;
  logic [1:0] in_frame_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [5:0] out_slot;
  logic [2:0] out_status;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  slot_allocator_deferred_reclaim_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // heap predictor state
  logic [2:0] frames_reg;
  logic [6:0] slots_reg;
  bit live [CAP];
  bit expired [CAP];
  logic [31:0] key_tab [CAP];
  logic [5:0] free_stk [CAP];
  int free_n;
  logic [5:0] retired [MAXF][CAP];
  int retired_n [MAXF];
  int cur_frame;
  bit full_seen;
  bit dirty;

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int errors = 0;
  bit hold_off = 0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void heap_clear();
    int n;
    n = (slots_reg < 2) ? 2 : (slots_reg > CAP ? CAP : slots_reg);
    for (int i = 0; i < CAP; i++) begin
      live[i] = 0; expired[i] = 0; key_tab[i] = '0; free_stk[i] = '0;
    end
    for (int f = 0; f < MAXF; f++) retired_n[f] = 0;
    for (int i = 0; i + 1 < n; i++) free_stk[i] = 6'(n - 1 - i);
    free_n = n - 1;
    cur_frame = 0;
    full_seen = 0;
    dirty = 1;
  endfunction

  function automatic void push_res(logic [1:0] k, int s, logic [2:0] st, bit l);
    res_t r;
    r.kind = k; r.slot = 6'(s); r.status = st; r.last = l;
    expected_res = {expected_res, r};
  endfunction

  function automatic void retire_slot(int s);
    int f;
    f = cur_frame % MAXF;
    if (s == 0) return;
    if (retired_n[f] < CAP) begin
      retired[f][retired_n[f]] = 6'(s);
      retired_n[f]++;
    end
  endfunction

  function automatic void predict_heap(cmd_t c);
    logic [23:0] pair;
    int nf, f, n, s;
    case (c.action)
      ACT_LOOKUP: begin
        if (!c.refs_present) begin
          push_res(KIND_ANSWER, 0, STAT_NULL, 1);
          return;
        end
        pair = {c.texture_id, c.sampler_id};
        for (int i = 0; i < CAP; i++) begin
          if (live[i] && key_tab[i][31:8] == pair) begin
            if (key_tab[i][7:0] == c.generation) begin
              push_res(KIND_ANSWER, i, STAT_HIT, 1);
              return;
            end
            retire_slot(i);
            live[i] = 0; expired[i] = 0;
            break;
          end
        end
        if (free_n == 0) begin
          push_res(KIND_ANSWER, 0, full_seen ? STAT_FULL : STAT_FULL_FIRST, 1);
          full_seen = 1;
          return;
        end
        free_n--;
        s = free_stk[free_n];
        live[s] = 1; expired[s] = 0;
        key_tab[s] = {c.texture_id, c.sampler_id, c.generation};
        dirty = 1;
        push_res(KIND_WR_ENTRY, s, STAT_NONE, 0);
        push_res(KIND_ANSWER, s, STAT_ALLOC, 1);
      end
      ACT_BEGIN: begin
        nf = (frames_reg < 1) ? 1 : (frames_reg > MAXF ? MAXF : frames_reg);
        f = c.frame_number % nf;
        cur_frame = f;
        n = retired_n[f] > CAP - 1 ? CAP - 1 : retired_n[f];
        for (int i = 0; i < n; i++) begin
          dirty = 1;
          if (free_n < CAP) begin
            free_stk[free_n] = retired[f][i];
            free_n++;
          end
          push_res(KIND_WR_ERROR, retired[f][i], STAT_NONE, 0);
        end
        retired_n[f] = 0;
        for (int i = 0; i < CAP; i++) begin
          if (live[i] && expired[i]) begin
            retire_slot(i);
            live[i] = 0; expired[i] = 0;
          end
        end
        push_res(KIND_DONE, 0, STAT_NONE, 1);
      end
      ACT_RELEASE: begin
        for (int i = 0; i < CAP; i++)
          if (live[i] && key_tab[i][31:16] == c.texture_id && key_tab[i][7:0] == c.generation)
            expired[i] = 1;
        push_res(KIND_DONE, 0, STAT_NONE, 1);
      end
      default: begin
        push_res(KIND_DONE, 0, dirty ? STAT_COMMITTED : STAT_NONE, 1);
        dirty = 0;
      end
    endcase
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_heap({in_action, in_texture_id, in_sampler_id, in_generation,
                    in_refs_present, in_frame_number});
    end
  end
  // the accepted flag is latched at posedge, acted on at negedge
  bit took;
  always @(posedge clk) took <= rst_n && in_valid && !in_stall;
  always @(negedge clk) begin
    cmd_t c;
    if (rst_n) begin
      if (!in_valid || took) begin
        if (send_gap > 0 || pending_cmds.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          {in_action, in_texture_id, in_sampler_id, in_generation,
           in_refs_present, in_frame_number} <= c;
          send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
          if ($urandom_range(0, 2) == 0) send_gap = 0;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        report($sformatf("unexpected result kind %0d slot %0d", out_result_kind, out_slot));
      end else begin
        e = expected_res.pop_front();
        if (out_result_kind !== e.kind)
          report($sformatf("kind %0d, want %0d", out_result_kind, e.kind));
        if (out_slot !== e.slot)
          report($sformatf("slot %0d, want %0d", out_slot, e.slot));
        if (out_status !== e.status)
          report($sformatf("status %0d, want %0d", out_status, e.status));
        if (out_last !== e.last)
          report($sformatf("last %0d, want %0d", out_last, e.last));
      end
    end
  end
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      out_stall <= 1'b1;
      recv_gap--;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall && $urandom_range(0, 2) != 0)
        recv_gap = $urandom_range(0, 18);
    end
  end

  task automatic add_cmd(logic [1:0] a, logic [15:0] t, logic [7:0] s, logic [7:0] g,
                         bit r, logic [1:0] f);
    cmd_t c;
    c = {a, t, s, g, r, f};
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FRAMES) frames_reg = val[2:0]; else slots_reg = val;
    heap_clear();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int tex_pool);
    int a;
    repeat (n) begin
      a = $urandom_range(0, 99);
      if (a < 60)
        add_cmd(ACT_LOOKUP, 16'($urandom_range(0, tex_pool)), 8'($urandom_range(0, 2)),
                8'($urandom_range(0, 2)), $urandom_range(0, 15) != 0, 2'($urandom));
      else if (a < 75)
        add_cmd(ACT_BEGIN, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                2'($urandom));
      else if (a < 90)
        add_cmd(ACT_RELEASE, 16'($urandom_range(0, tex_pool)), 8'($urandom),
                8'($urandom_range(0, 2)), 1'($urandom), 2'($urandom));
      else if (a < 95)
        add_cmd(ACT_COMMIT, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                2'($urandom));
      else
        add_cmd(ACT_LOOKUP, 16'($urandom), 8'($urandom), 8'($urandom), 1'b1, 2'($urandom));
    end
  endtask

  initial begin
    frames_reg = RST_FRAMES;
    slots_reg = RST_SLOTS;
    heap_clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    add_cmd(ACT_COMMIT, 0, 0, 0, 0, 0);
    add_cmd(ACT_COMMIT, 0, 0, 0, 0, 0);
    add_cmd(ACT_LOOKUP, 16'hFFFF, 8'hFF, 8'hFF, 0, 3);
    add_cmd(ACT_LOOKUP, 16'hFFFF, 8'hFF, 8'hFF, 1, 3);
    add_cmd(ACT_LOOKUP, 16'hFFFF, 8'hFF, 8'hFF, 1, 3);
    add_cmd(ACT_LOOKUP, 16'hFFFF, 8'hFF, 8'h00, 1, 0);
    add_cmd(ACT_LOOKUP, 16'h0000, 8'h00, 8'h00, 1, 0);
    add_cmd(ACT_RELEASE, 16'h0000, 8'h55, 8'h00, 0, 0);
    add_cmd(ACT_RELEASE, 16'hFFFF, 8'h00, 8'h00, 1, 0);
    add_cmd(ACT_BEGIN, 0, 0, 0, 0, 3);
    add_cmd(ACT_BEGIN, 0, 0, 0, 0, 1);
    add_cmd(ACT_BEGIN, 0, 0, 0, 0, 0);
    add_cmd(ACT_COMMIT, 0, 0, 0, 1, 2);
    wait_idle();

    // small heap to reach full
    write_reg(CFG_SLOTS, 7'd3);
    write_reg(CFG_FRAMES, 3'd4);
    for (int i = 0; i < 4; i++) add_cmd(ACT_LOOKUP, 16'(i), 8'd1, 8'd1, 1, 0);
    add_cmd(ACT_LOOKUP, 16'd0, 8'd1, 8'd2, 1, 0);
    add_cmd(ACT_BEGIN, 0, 0, 0, 0, 0);
    add_cmd(ACT_LOOKUP, 16'd9, 8'd1, 8'd1, 1, 0);
    wait_idle();

    write_reg(CFG_SLOTS, 7'd0);
    write_reg(CFG_FRAMES, 3'd0);
    random_phase(40, 3);
    wait_idle();

    write_reg(CFG_FRAMES, 3'd7);
    write_reg(CFG_SLOTS, 7'd127);
    hold_off = 1;
    random_phase(20, 15);
    fork
      begin repeat (300) @(negedge clk); hold_off = 0; end
    join_none
    random_phase(100, 15);
    wait_idle();

    write_reg(CFG_SLOTS, 7'd8);
    write_reg(CFG_FRAMES, 3'd1);
    random_phase(100, 7);
    wait_idle();

    write_reg(CFG_SLOTS, 7'd64);
    write_reg(CFG_FRAMES, 3'd3);
    random_phase(180, 40);
    wait_idle();

    if (errors == 0)
      $display("slot_allocator_deferred_reclaim_top test passed");
    else
      $display("slot_allocator_deferred_reclaim_top test failed");
    $finish;
  end

  initial begin
    #60ms;
    $display("slot_allocator_deferred_reclaim_top test failed");
    $finish;
  end
endmodule
